// ----- hdl/nearest_centroid_classifier_core_macros.svh -----
// Assertion macros shared by the classifier RTL files.
`ifndef NEAREST_CENTROID_CLASSIFIER_CORE_MACROS_SVH
`define NEAREST_CENTROID_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define NCC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("classifier check failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define NCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("classifier check failed: next-cycle implication");

`endif

// ----- hdl/ncc_pkg.sv -----
// Shared constants, types and helpers for the nearest centroid classifier.
package ncc_pkg;

  localparam int FEATURE_WIDTH = 10;
  localparam int NUM_FEATURES  = 4;
  localparam int NUM_CLASSES   = 3;
  localparam int CENT_W        = 10;
  localparam int CLS_W         = 2;
  localparam int DIST_W        = 11;

  localparam int DIFF_W  = (FEATURE_WIDTH > CENT_W) ? FEATURE_WIDTH : CENT_W;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int WIDE_W  = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

  // Two front stages, one cell per root bit, one output register.
  localparam int LATENCY = ROOT_W + 3;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [CLS_W-1:0] CLASS_SETOSA     = 2'd0;
  localparam logic [CLS_W-1:0] CLASS_VIRGINICA  = 2'd1;
  localparam logic [CLS_W-1:0] CLASS_VERSICOLOR = 2'd2;

  // Centroids in hundredths, one row per class.
  localparam logic [CENT_W-1:0] CENTROIDS [NUM_CLASSES][NUM_FEATURES] = '{
    '{10'd685, 10'd307, 10'd574, 10'd207},
    '{10'd500, 10'd341, 10'd146, 10'd24},
    '{10'd590, 10'd274, 10'd439, 10'd143}
  };

  typedef logic [FEATURE_WIDTH-1:0] feature_t;
  typedef logic [SUM_W-1:0]         sum_t;

  // Control that travels down the root chain next to the data.
  typedef struct packed {
    logic             valid;
    logic [CLS_W-1:0] class_index;
  } ncc_tag_t;

  // Working set of one square root in flight.
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } ncc_lane_t;

  function automatic logic [DIST_W-1:0] sat_dist(input logic [ROOT_W-1:0] root);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(root);
    if (wide > WIDE_W'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return DIST_W'(wide);
  endfunction

endpackage

// ----- hdl/ncc_front.sv -----
// Front end: absolute differences, squares and per-class sums of squares.
`include "nearest_centroid_classifier_core_macros.svh"

module ncc_front
  import ncc_pkg::*;
(
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  feature_t [NUM_FEATURES-1:0]          features,
  output logic                                 sum_valid,
  output sum_t [NUM_CLASSES-1:0]               sums
);

  logic [SQ_W-1:0] sq_next [NUM_CLASSES][NUM_FEATURES];
  logic [SQ_W-1:0] sq      [NUM_CLASSES][NUM_FEATURES];
  logic            sq_valid;
  sum_t [NUM_CLASSES-1:0] sums_next;

  always_comb begin
    logic [DIFF_W-1:0] x;
    logic [DIFF_W-1:0] c;
    logic [DIFF_W-1:0] d;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      for (int f = 0; f < NUM_FEATURES; f++) begin
        x = DIFF_W'(features[f]);
        c = DIFF_W'(CENTROIDS[k][f]);
        d = (x >= c) ? (x - c) : (c - x);
        sq_next[k][f] = SQ_W'(d) * SQ_W'(d);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      sums_next[k] = SUM_W'(sq[k][0]) + SUM_W'(sq[k][1])
                   + SUM_W'(sq[k][2]) + SUM_W'(sq[k][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      sq_valid  <= load;
      sum_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq   <= sq_next;
    sums <= sums_next;
  end

  `NCC_ASSERT_NEXT(a_front_two_stages, clk, rst, $past(load), sum_valid)

endmodule

// ----- hdl/ncc_cell.sv -----
// One square-root cell: resolves one root bit for every class per cycle.
`include "nearest_centroid_classifier_core_macros.svh"

module ncc_cell
  import ncc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  ncc_tag_t                      tag_in,
  input  ncc_lane_t [NUM_CLASSES-1:0]   lane_in,
  output ncc_tag_t                      tag_out,
  output ncc_lane_t [NUM_CLASSES-1:0]   lane_out
);

  ncc_lane_t [NUM_CLASSES-1:0] lane_next;

  // Restoring digit step: bring down two radicand bits, try root*4+1.
  always_comb begin
    logic [REM_W+1:0] cand;
    logic [REM_W+1:0] trial;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      cand  = {lane_in[k].rem, lane_in[k].rad[RAD_W-1 -: 2]};
      trial = {{(REM_W - ROOT_W){1'b0}}, lane_in[k].root, 2'b01};
      lane_next[k].rad = {lane_in[k].rad[RAD_W-3:0], 2'b00};
      if (cand >= trial) begin
        lane_next[k].rem  = REM_W'(cand - trial);
        lane_next[k].root = {lane_in[k].root[ROOT_W-2:0], 1'b1};
      end else begin
        lane_next[k].rem  = cand[REM_W-1:0];
        lane_next[k].root = {lane_in[k].root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_out.class_index <= tag_in.class_index;
    lane_out            <= lane_next;
  end

  // The partial remainder never exceeds twice the partial root.
  for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_chk
    `NCC_ASSERT_IMPLIES(a_rem_bound, clk, rst, tag_out.valid, (lane_out[k].rem <= {1'b0, lane_out[k].root, 1'b0}))
  end

endmodule

// ----- hdl/nearest_centroid_classifier_core.sv -----
// Top level of the three-class, four-feature nearest centroid classifier.
// The start transfer reaches done through two front stages, eleven square-root cells
// and one output register.
// Throughput: one item per clock; busy is low whenever rst is low, so start may stay high.
// Each result is shown for exactly one cycle and the receiver cannot stall it.
// Reset (rst, synchronous) clears every valid flag in the pipeline; items in flight are dropped.
`include "nearest_centroid_classifier_core_macros.svh"

module nearest_centroid_classifier_core
  import ncc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [FEATURE_WIDTH-1:0] petal_length,
  input  logic [FEATURE_WIDTH-1:0] petal_width,
  input  logic [FEATURE_WIDTH-1:0] sepal_length,
  input  logic [FEATURE_WIDTH-1:0] sepal_width,
  output logic                     done,
  output logic [CLS_W-1:0]         class_index,
  output logic [DIST_W-1:0]        distance_one,
  output logic [DIST_W-1:0]        distance_two,
  output logic [DIST_W-1:0]        distance_three
);

  // The pipeline never stops, so the only time a transfer is refused is
  // during reset.
  logic load;
  assign busy = rst;
  assign load = start && !busy;

  // Front end: the four features are compared with all three centroids at
  // once. After two register stages the exact sums of squares are ready.
  feature_t [NUM_FEATURES-1:0] features;
  logic                        sum_valid;
  sum_t [NUM_CLASSES-1:0]      sums;

  assign features[0] = petal_length;
  assign features[1] = petal_width;
  assign features[2] = sepal_length;
  assign features[3] = sepal_width;

  ncc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .features  (features),
    .sum_valid (sum_valid),
    .sums      (sums)
  );

  // The class is chosen on the exact sums, not on the floored distances.
  // Strict compares give ties to the lowest class index. The three compares
  // run side by side, and the winner rides down the chain in the tag.
  logic [CLS_W-1:0] best_class;

  always_comb begin
    if ((sums[2] < sums[0]) && (sums[2] < sums[1])) begin
      best_class = CLASS_VERSICOLOR;
    end else if (sums[1] < sums[0]) begin
      best_class = CLASS_VIRGINICA;
    end else begin
      best_class = CLASS_SETOSA;
    end
  end

  // Square-root chain: one cell per root bit, most significant first. Each
  // cell takes two radicand bits from the top, so after ROOT_W cells every
  // lane holds the floor of its square root.
  ncc_tag_t                    tag_chain  [ROOT_W+1];
  ncc_lane_t [NUM_CLASSES-1:0] lane_chain [ROOT_W+1];

  always_comb begin
    tag_chain[0].valid       = sum_valid;
    tag_chain[0].class_index = best_class;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      lane_chain[0][k].rad  = RAD_W'(sums[k]);
      lane_chain[0][k].rem  = '0;
      lane_chain[0][k].root = '0;
    end
  end

  for (genvar s = 0; s < ROOT_W; s++) begin : g_cell
    ncc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .tag_in   (tag_chain[s]),
      .lane_in  (lane_chain[s]),
      .tag_out  (tag_chain[s+1]),
      .lane_out (lane_chain[s+1])
    );
  end

  // Output register: distances saturate at the port width, which only
  // matters for feature widths above ten bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag_chain[ROOT_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    class_index    <= tag_chain[ROOT_W].class_index;
    distance_one   <= sat_dist(lane_chain[ROOT_W][0].root);
    distance_two   <= sat_dist(lane_chain[ROOT_W][1].root);
    distance_three <= sat_dist(lane_chain[ROOT_W][2].root);
  end

  // Every result comes from an earlier start transfer.
  `NCC_ASSERT_IMPLIES(a_done_from_transfer, clk, rst, done, $past(load, LATENCY))
  // Flooring is monotonic, so the chosen class never shows a larger distance.
  `NCC_ASSERT_IMPLIES(a_best_is_nearest, clk, rst, done, (class_index != CLASS_SETOSA || (distance_one <= distance_two && distance_one <= distance_three)) && (class_index != CLASS_VIRGINICA || (distance_two <= distance_one && distance_two <= distance_three)) && (class_index != CLASS_VERSICOLOR || (distance_three <= distance_one && distance_three <= distance_two)))

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the nearest centroid classifier core.
`timescale 1ns / 100ps

module tb_top
  import ncc_pkg::*;
();

  // A flower is four features; index 0 is petal length, 3 is sepal width.
  typedef feature_t [NUM_FEATURES-1:0] flower_t;

  // One classification: the winning class and the floored distance to each centroid.
  typedef struct packed {
    logic [CLS_W-1:0]                      class_index;
    logic [NUM_CLASSES-1:0][DIST_W-1:0]    reach;
  } verdict_t;

  localparam int FEAT_MAX = (1 << FEATURE_WIDTH) - 1;

  // Centroids in hundredths, one row per class, in feature order.
  localparam int CENTER [NUM_CLASSES][NUM_FEATURES] = '{
    '{685, 307, 574, 207},
    '{500, 341, 146, 24},
    '{590, 274, 439, 143}
  };

  localparam logic [CLS_W-1:0] CLASS_CODES [NUM_CLASSES] =
    '{CLASS_SETOSA, CLASS_VIRGINICA, CLASS_VERSICOLOR};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [FEATURE_WIDTH-1:0] petal_length = '0;
  logic [FEATURE_WIDTH-1:0] petal_width = '0;
  logic [FEATURE_WIDTH-1:0] sepal_length = '0;
  logic [FEATURE_WIDTH-1:0] sepal_width = '0;
  logic                     done;
  logic [CLS_W-1:0]         class_index;
  logic [DIST_W-1:0]        distance_one;
  logic [DIST_W-1:0]        distance_two;
  logic [DIST_W-1:0]        distance_three;

  flower_t  flower_q[$];          // flowers still to be offered to the core
  verdict_t pending_verdicts[$];  // predicted results of accepted flowers, oldest first
  logic     xfer_taken = 1'b0;    // the last rising edge completed a start transfer
  int       gap_left = 0;
  int       quiet_left = 0;
  int       mismatches = 0;

  nearest_centroid_classifier_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .petal_length   (petal_length),
    .petal_width    (petal_width),
    .sepal_length   (sepal_length),
    .sepal_width    (sepal_width),
    .done           (done),
    .class_index    (class_index),
    .distance_one   (distance_one),
    .distance_two   (distance_two),
    .distance_three (distance_three)
  );

  // Squared Euclidean distance to one centroid, in units of 0.0001.
  function automatic longint unsigned sum_sq(flower_t x, int k);
    longint unsigned acc;
    int diff;
    acc = 0;
    for (int f = 0; f < NUM_FEATURES; f++) begin
      diff = int'(x[f]) - CENTER[k][f];
      acc += longint'(diff * diff);
    end
    return acc;
  endfunction

  // Floor of the square root, built one root bit at a time from the top.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = r | (longint'(1) << b);
      if (trial * trial <= v) begin
        r = trial;
      end
    end
    return r;
  endfunction

  // Expected result for one flower. The class is chosen on the exact sums of
  // squares, so flooring never creates a tie; on a real tie the lower class wins.
  function automatic verdict_t classify_flower(flower_t x);
    verdict_t        v;
    longint unsigned sq [NUM_CLASSES];
    longint unsigned best_sq;
    longint unsigned r;
    int              best;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      sq[k] = sum_sq(x, k);
    end
    best = 0;
    best_sq = sq[0];
    for (int k = 1; k < NUM_CLASSES; k++) begin
      if (sq[k] < best_sq) begin
        best_sq = sq[k];
        best = k;
      end
    end
    v.class_index = CLASS_CODES[best];
    for (int k = 0; k < NUM_CLASSES; k++) begin
      r = floor_root(sq[k]);
      v.reach[k] = (r > longint'(DIST_MAX)) ? DIST_MAX : DIST_W'(r);
    end
    return v;
  endfunction

  function automatic feature_t clamp_feat(int v);
    if (v < 0) begin
      return '0;
    end
    if (v > FEAT_MAX) begin
      return FEATURE_WIDTH'(FEAT_MAX);
    end
    return FEATURE_WIDTH'(v);
  endfunction

  // Searches for a flower exactly equidistant from classes a and b (a < b) and
  // strictly farther from the third, so the tie decides the class. The tie
  // condition is linear in the features: sum 2*x*(cb - ca) = sum (cb^2 - ca^2).
  // Three features are drawn near the midpoint and the fourth is solved for.
  // When the right-hand side is odd no integer tie exists and the search gives up.
  function automatic bit find_tie(int a, int b, output flower_t x);
    int d [NUM_FEATURES];
    int s;
    int r;
    int x3;
    int third;
    s = 0;
    third = 3 - a - b;
    x = '0;
    for (int f = 0; f < NUM_FEATURES; f++) begin
      d[f] = CENTER[b][f] - CENTER[a][f];
      s += CENTER[b][f] * CENTER[b][f] - CENTER[a][f] * CENTER[a][f];
    end
    for (int tries = 0; tries < 5000; tries++) begin
      r = s;
      for (int f = 0; f < NUM_FEATURES - 1; f++) begin
        x[f] = clamp_feat((CENTER[a][f] + CENTER[b][f]) / 2
                          + int'($urandom_range(0, 80)) - 40);
        r -= 2 * int'(x[f]) * d[f];
      end
      if (r % (2 * d[3]) == 0) begin
        x3 = r / (2 * d[3]);
        if (x3 >= 0 && x3 <= FEAT_MAX) begin
          x[3] = FEATURE_WIDTH'(x3);
          if (sum_sq(x, third) > sum_sq(x, a)) begin
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Clock and the single reset pulse; reset is released on a falling edge.
  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
  end

  // Driver. Inputs change on the falling edge only. A flower stays on the
  // ports with start high until a rising edge sees start high and busy low;
  // the next one may follow at once, so start can stay high across transfers.
  // Idle bursts come at random, except during quiet stretches and over the
  // last part of the run. During idle bursts the feature ports carry noise
  // or a stale flower, which the core must ignore.
  always @(negedge clk) begin : driver
    flower_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !xfer_taken) begin
      // Hold the current flower until it has been transferred.
    end else if (gap_left > 0) begin
      start        <= 1'b0;
      gap_left     <= gap_left - 1;
      petal_length <= FEATURE_WIDTH'($urandom);
      petal_width  <= FEATURE_WIDTH'($urandom);
      sepal_length <= FEATURE_WIDTH'($urandom);
      sepal_width  <= FEATURE_WIDTH'($urandom);
    end else if (flower_q.size() > 0) begin
      if (quiet_left == 0 && flower_q.size() > 150 && $urandom_range(0, 4) == 0) begin
        start    <= 1'b0;
        gap_left <= $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) begin
          quiet_left <= $urandom_range(10, 60);
        end
      end else begin
        nxt = flower_q.pop_front();
        start        <= 1'b1;
        petal_length <= nxt[0];
        petal_width  <= nxt[1];
        sepal_length <= nxt[2];
        sepal_width  <= nxt[3];
        if (quiet_left > 0) begin
          quiet_left <= quiet_left - 1;
        end
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor. On each rising edge it first checks a result shown by done
  // against the oldest prediction, then records a prediction for a flower
  // transferred at this edge. The result cannot be held off, so every done
  // cycle is one result.
  always @(posedge clk) begin : monitor
    verdict_t got;
    verdict_t want;
    bit       bad;
    xfer_taken <= !rst && start && !busy;
    if (!rst && done) begin
      got.class_index = class_index;
      got.reach[0]    = distance_one;
      got.reach[1]    = distance_two;
      got.reach[2]    = distance_three;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing outstanding: class %0d, distances %0d %0d %0d",
                   $realtime, got.class_index, got.reach[0], got.reach[1], got.reach[2]);
        end
      end else begin
        want = pending_verdicts.pop_front();
        bad = (got.class_index !== want.class_index);
        for (int k = 0; k < NUM_CLASSES; k++) begin
          if (got.reach[k] !== want.reach[k]) begin
            bad = 1'b1;
          end
        end
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch: expected class %0d, distances %0d %0d %0d;",
                     $realtime, want.class_index, want.reach[0], want.reach[1],
                     want.reach[2]);
            $display("    got class %0d, distances %0d %0d %0d",
                     got.class_index, got.reach[0], got.reach[1], got.reach[2]);
          end
        end
      end
    end
    if (!rst && start && !busy) begin
      pending_verdicts.push_back(
        classify_flower({sepal_width, sepal_length, petal_width, petal_length}));
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    flower_t x;
    int      a;
    int      b;
    int      pick;

    // Directed part: the all-zero and all-ones corners of the feature space, each
    // centroid exactly (distance zero), each feature alone at full scale, alternating
    // bit patterns, and an exact tie for each pair of classes where one is found.
    flower_q.push_back('0);
    flower_q.push_back('1);
    for (int k = 0; k < NUM_CLASSES; k++) begin
      for (int f = 0; f < NUM_FEATURES; f++) begin
        x[f] = FEATURE_WIDTH'(CENTER[k][f]);
      end
      flower_q.push_back(x);
    end
    for (int f = 0; f < NUM_FEATURES; f++) begin
      x = '0;
      x[f] = FEATURE_WIDTH'(FEAT_MAX);
      flower_q.push_back(x);
    end
    for (int f = 0; f < NUM_FEATURES; f++) begin
      x[f] = {FEATURE_WIDTH/2{2'b10}};
    end
    flower_q.push_back(x);
    for (int f = 0; f < NUM_FEATURES; f++) begin
      x[f] = {FEATURE_WIDTH/2{2'b01}};
    end
    flower_q.push_back(x);
    for (a = 0; a < NUM_CLASSES; a++) begin
      for (b = a + 1; b < NUM_CLASSES; b++) begin
        if (find_tie(a, b, x)) begin
          flower_q.push_back(x);
        end
      end
    end

    // Random part: flowers scattered around the centroids (the largest share), where the
    // decision is close, plus uniform flowers, full-scale corners and ties.
    for (int n = 0; n < 1190; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        a = $urandom_range(0, NUM_CLASSES - 1);
        for (int f = 0; f < NUM_FEATURES; f++) begin
          x[f] = clamp_feat(CENTER[a][f] + int'($urandom_range(0, 240)) - 120);
        end
      end else if (pick < 75) begin
        for (int f = 0; f < NUM_FEATURES; f++) begin
          x[f] = FEATURE_WIDTH'($urandom);
        end
      end else if (pick < 90) begin
        for (int f = 0; f < NUM_FEATURES; f++) begin
          case ($urandom_range(0, 2))
            0: x[f] = '0;
            1: x[f] = '1;
            default: x[f] = FEATURE_WIDTH'($urandom);
          endcase
        end
      end else begin
        a = $urandom_range(0, 1);
        b = $urandom_range(a + 1, NUM_CLASSES - 1);
        if (!find_tie(a, b, x)) begin
          x = (FEATURE_WIDTH * NUM_FEATURES)'({$urandom, $urandom});
        end
      end
      flower_q.push_back(x);
    end

    // Every flower has been transferred once the queue is empty and start
    // has dropped; then wait for the outstanding results and a drain period.
    @(negedge clk);
    while (rst || flower_q.size() != 0 || start) begin
      @(negedge clk);
    end
    while (pending_verdicts.size() != 0) begin
      @(negedge clk);
    end
    repeat (LATENCY + 4) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (every flower behind a
  // full-length idle burst, plus the pipeline latency).
  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ncc_pkg.sv
hdl/ncc_front.sv
hdl/ncc_cell.sv
hdl/nearest_centroid_classifier_core.sv
sim/tb_top.sv
